[src/crg_pkg.sv]
// ----------------------------------------------------------------------------
// crg_pkg
// shared types, constants and rounding helper for the camera ray generator
// ----------------------------------------------------------------------------
package crg_pkg;

	localparam int MAX_DIM   = 4096;
	localparam int FRAC_BITS = 14;
	localparam int TAN_FRAC  = 12;
	localparam int ONE       = 1 << FRAC_BITS;

	localparam int PIX_W  = 12;
	localparam int DIM_W  = 13;
	localparam int TAN_W  = 16;
	localparam int VEC_W  = 16;
	localparam int RAW_W  = 17;
	localparam int MAG_W  = 29;
	localparam int SQ_W   = 2 * MAG_W;
	localparam int SUM_W  = SQ_W + 2;
	localparam int ROOT_W = SUM_W / 2;
	localparam int REM_W  = ROOT_W + 2;
	localparam int QUO_W  = FRAC_BITS + 1;
	localparam int DVD_W  = MAG_W + FRAC_BITS + 1;
	localparam int SH_N   = 5;
	localparam int PROD_W = 32;

	localparam int BASIS_CYCLES = 72;
	localparam int CNT_W        = 7;

	typedef enum logic [2:0] {
		REG_WIDTH,
		REG_HEIGHT,
		REG_TAN,
		REG_DIR_X,
		REG_DIR_Y,
		REG_DIR_Z
	} reg_idx_t;

	typedef enum logic [1:0] {
		KIND_PIX,
		KIND_FWD,
		KIND_SIDE
	} kind_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_x;
		logic [PIX_W-1:0] pixel_y;
	} pixel_t;

	typedef struct packed {
		logic signed [VEC_W-1:0] ray_x;
		logic signed [VEC_W-1:0] ray_y;
		logic signed [VEC_W-1:0] ray_z;
		logic                    degenerate;
		logic                    out_of_frame;
	} ray_t;

	typedef struct packed {
		logic [DIM_W-1:0]        frame_width;
		logic [DIM_W-1:0]        frame_height;
		logic [TAN_W-1:0]        tan_half_fov;
		logic signed [VEC_W-1:0] dir_x;
		logic signed [VEC_W-1:0] dir_y;
		logic signed [VEC_W-1:0] dir_z;
	} cfg_t;

	typedef struct packed {
		kind_t      kind;
		logic       oof;
		logic [2:0] neg;
	} side_t;

	// shift right by FRAC_BITS, ties away from zero, clamp to +-ONE
	function automatic logic signed [VEC_W-1:0] rnd_clamp(input logic signed [PROD_W-1:0] v);
		logic [PROD_W-1:0] mag;
		logic [PROD_W-1:0] q;
		logic [VEC_W-1:0]  lim;
		mag = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
		q = (mag + PROD_W'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
		lim = (q > PROD_W'(ONE)) ? VEC_W'(ONE) : q[VEC_W-1:0];
		return v[PROD_W-1] ? -$signed(lim) : $signed(lim);
	endfunction

endpackage

[src/crg_regs.sv]
// ----------------------------------------------------------------------------
// crg_regs
// apb register file holding frame size, field of view and view direction
// ----------------------------------------------------------------------------
module crg_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [4:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	output crg_pkg::cfg_t       cfg,
	output logic                wr
);

	crg_pkg::cfg_t    cfg_q;
	crg_pkg::reg_idx_t idx;

	assign idx    = crg_pkg::reg_idx_t'(paddr[4:2]);
	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width  <= crg_pkg::DIM_W'(640);
			cfg_q.frame_height <= crg_pkg::DIM_W'(480);
			cfg_q.tan_half_fov <= crg_pkg::TAN_W'(4096);
			cfg_q.dir_x        <= '0;
			cfg_q.dir_y        <= '0;
			cfg_q.dir_z        <= 16'shC000;
		end else if (wr) begin
			case (idx)
				crg_pkg::REG_WIDTH:  cfg_q.frame_width  <= pwdata[crg_pkg::DIM_W-1:0];
				crg_pkg::REG_HEIGHT: cfg_q.frame_height <= pwdata[crg_pkg::DIM_W-1:0];
				crg_pkg::REG_TAN:    cfg_q.tan_half_fov <= pwdata[crg_pkg::TAN_W-1:0];
				crg_pkg::REG_DIR_X:  cfg_q.dir_x        <= $signed(pwdata[crg_pkg::VEC_W-1:0]);
				crg_pkg::REG_DIR_Y:  cfg_q.dir_y        <= $signed(pwdata[crg_pkg::VEC_W-1:0]);
				crg_pkg::REG_DIR_Z:  cfg_q.dir_z        <= $signed(pwdata[crg_pkg::VEC_W-1:0]);
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			crg_pkg::REG_WIDTH:  prdata = 32'(cfg_q.frame_width);
			crg_pkg::REG_HEIGHT: prdata = 32'(cfg_q.frame_height);
			crg_pkg::REG_TAN:    prdata = 32'(cfg_q.tan_half_fov);
			crg_pkg::REG_DIR_X:  prdata = 32'(unsigned'(cfg_q.dir_x));
			crg_pkg::REG_DIR_Y:  prdata = 32'(unsigned'(cfg_q.dir_y));
			crg_pkg::REG_DIR_Z:  prdata = 32'(unsigned'(cfg_q.dir_z));
			default:             prdata = '0;
		endcase
	end

endmodule

[src/crg_norm.sv]
// ----------------------------------------------------------------------------
// crg_norm
// pipelined vector normalizer: leading-one shift, sum of squares,
// digit-by-digit square root and restoring division, one stage per digit
// ----------------------------------------------------------------------------
module crg_norm (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	input  crg_pkg::side_t                        in_side,
	input  logic [2:0][crg_pkg::MAG_W-1:0]        in_mag,
	output logic                                  out_valid,
	output crg_pkg::side_t                        out_side,
	output logic [2:0][crg_pkg::VEC_W-1:0]        out_vec
);

	localparam int SH_N  = crg_pkg::SH_N;
	localparam int MAG_W = crg_pkg::MAG_W;
	localparam int RT_N  = crg_pkg::ROOT_W;
	localparam int DV_N  = crg_pkg::QUO_W;

	// leading-one shift
	logic                   sh_valid_sn [SH_N+1];
	crg_pkg::side_t         sh_side_sn  [SH_N+1];
	logic [2:0][MAG_W-1:0]  sh_mag_sn   [SH_N+1];
	logic [MAG_W-1:0]       sh_or_sn    [SH_N+1];

	assign sh_valid_sn[0] = in_valid;
	assign sh_side_sn[0]  = in_side;
	assign sh_mag_sn[0]   = in_mag;
	assign sh_or_sn[0]    = in_mag[0] | in_mag[1] | in_mag[2];

	for (genvar k = 0; k < SH_N; k++) begin : g_shift
		localparam int AMT = 1 << (SH_N - 1 - k);
		logic hit;
		assign hit = (sh_or_sn[k][MAG_W-1 -: AMT] == '0);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sh_valid_sn[k+1] <= 1'b0;
			else         sh_valid_sn[k+1] <= sh_valid_sn[k];
		end

		always_ff @(posedge clk) begin
			sh_side_sn[k+1] <= sh_side_sn[k];
			if (hit) begin
				sh_or_sn[k+1] <= sh_or_sn[k] << AMT;
				for (int i = 0; i < 3; i++) sh_mag_sn[k+1][i] <= sh_mag_sn[k][i] << AMT;
			end else begin
				sh_or_sn[k+1]  <= sh_or_sn[k];
				sh_mag_sn[k+1] <= sh_mag_sn[k];
			end
		end
	end

	// squares and sum
	logic                            sq_valid_s6;
	crg_pkg::side_t                  sq_side_s6;
	logic [2:0][MAG_W-1:0]           sq_mag_s6;
	logic [2:0][crg_pkg::SQ_W-1:0]   sq_s6;
	logic                            sum_valid_s7;
	crg_pkg::side_t                  sum_side_s7;
	logic [2:0][MAG_W-1:0]           sum_mag_s7;
	logic [crg_pkg::SUM_W-1:0]       sum_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_valid_s6  <= 1'b0;
			sum_valid_s7 <= 1'b0;
		end else begin
			sq_valid_s6  <= sh_valid_sn[SH_N];
			sum_valid_s7 <= sq_valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		sq_side_s6 <= sh_side_sn[SH_N];
		sq_mag_s6  <= sh_mag_sn[SH_N];
		for (int i = 0; i < 3; i++) sq_s6[i] <= sh_mag_sn[SH_N][i] * sh_mag_sn[SH_N][i];
		sum_side_s7 <= sq_side_s6;
		sum_mag_s7  <= sq_mag_s6;
		sum_s7      <= crg_pkg::SUM_W'(sq_s6[0]) + crg_pkg::SUM_W'(sq_s6[1])
		             + crg_pkg::SUM_W'(sq_s6[2]);
	end

	// square root, two radicand bits per stage
	logic                          rt_valid_sn [RT_N+1];
	crg_pkg::side_t                rt_side_sn  [RT_N+1];
	logic [2:0][MAG_W-1:0]         rt_mag_sn   [RT_N+1];
	logic [crg_pkg::SUM_W-1:0]     rt_rad_sn   [RT_N+1];
	logic [crg_pkg::REM_W-1:0]     rt_rem_sn   [RT_N+1];
	logic [crg_pkg::ROOT_W-1:0]    rt_root_sn  [RT_N+1];

	assign rt_valid_sn[0] = sum_valid_s7;
	assign rt_side_sn[0]  = sum_side_s7;
	assign rt_mag_sn[0]   = sum_mag_s7;
	assign rt_rad_sn[0]   = sum_s7;
	assign rt_rem_sn[0]   = '0;
	assign rt_root_sn[0]  = '0;

	for (genvar j = 0; j < RT_N; j++) begin : g_sqrt
		logic [crg_pkg::REM_W+1:0] acc;
		logic [crg_pkg::REM_W+1:0] trial;
		logic                      ge;
		assign acc   = {rt_rem_sn[j], rt_rad_sn[j][crg_pkg::SUM_W-1 -: 2]};
		assign trial = {2'b00, rt_root_sn[j], 2'b01};
		assign ge    = (acc >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) rt_valid_sn[j+1] <= 1'b0;
			else         rt_valid_sn[j+1] <= rt_valid_sn[j];
		end

		always_ff @(posedge clk) begin
			rt_side_sn[j+1] <= rt_side_sn[j];
			rt_mag_sn[j+1]  <= rt_mag_sn[j];
			rt_rad_sn[j+1]  <= rt_rad_sn[j] << 2;
			rt_rem_sn[j+1]  <= ge ? crg_pkg::REM_W'(acc - trial) : crg_pkg::REM_W'(acc);
			rt_root_sn[j+1] <= {rt_root_sn[j][crg_pkg::ROOT_W-2:0], ge};
		end
	end

	// division setup
	logic                               dp_valid_s38;
	crg_pkg::side_t                     dp_side_s38;
	logic [crg_pkg::ROOT_W-1:0]         dp_m_s38;
	logic [2:0][crg_pkg::DVD_W-1:0]     dp_rem_s38;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dp_valid_s38 <= 1'b0;
		else         dp_valid_s38 <= rt_valid_sn[RT_N];
	end

	always_ff @(posedge clk) begin
		dp_side_s38 <= rt_side_sn[RT_N];
		dp_m_s38    <= rt_root_sn[RT_N];
		for (int i = 0; i < 3; i++)
			dp_rem_s38[i] <= crg_pkg::DVD_W'({rt_mag_sn[RT_N][i], crg_pkg::FRAC_BITS'(0)})
			               + crg_pkg::DVD_W'(rt_root_sn[RT_N] >> 1);
	end

	// restoring division, one quotient bit per stage
	logic                               dv_valid_sn [DV_N+1];
	crg_pkg::side_t                     dv_side_sn  [DV_N+1];
	logic [crg_pkg::ROOT_W-1:0]         dv_m_sn     [DV_N+1];
	logic [2:0][crg_pkg::DVD_W-1:0]     dv_rem_sn   [DV_N+1];
	logic [2:0][crg_pkg::QUO_W-1:0]     dv_q_sn     [DV_N+1];

	assign dv_valid_sn[0] = dp_valid_s38;
	assign dv_side_sn[0]  = dp_side_s38;
	assign dv_m_sn[0]     = dp_m_s38;
	assign dv_rem_sn[0]   = dp_rem_s38;
	assign dv_q_sn[0]     = '0;

	for (genvar k = 0; k < DV_N; k++) begin : g_div
		localparam int B = DV_N - 1 - k;
		logic [crg_pkg::DVD_W-1:0] sub;
		logic [2:0]                ge;
		assign sub = crg_pkg::DVD_W'(dv_m_sn[k]) << B;
		for (genvar i = 0; i < 3; i++) begin : g_lane
			assign ge[i] = (dv_rem_sn[k][i] >= sub);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_valid_sn[k+1] <= 1'b0;
			else         dv_valid_sn[k+1] <= dv_valid_sn[k];
		end

		always_ff @(posedge clk) begin
			dv_side_sn[k+1] <= dv_side_sn[k];
			dv_m_sn[k+1]    <= dv_m_sn[k];
			for (int i = 0; i < 3; i++) begin
				dv_rem_sn[k+1][i] <= ge[i] ? dv_rem_sn[k][i] - sub : dv_rem_sn[k][i];
				dv_q_sn[k+1][i]   <= dv_q_sn[k][i] | (crg_pkg::QUO_W'(ge[i]) << B);
			end
		end
	end

	// clamp and sign
	logic [2:0][crg_pkg::VEC_W-1:0] lim;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			lim[i] = (dv_q_sn[DV_N][i] > crg_pkg::QUO_W'(crg_pkg::ONE))
			       ? crg_pkg::VEC_W'(crg_pkg::ONE) : crg_pkg::VEC_W'(dv_q_sn[DV_N][i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else         out_valid <= dv_valid_sn[DV_N];
	end

	always_ff @(posedge clk) begin
		out_side <= dv_side_sn[DV_N];
		for (int i = 0; i < 3; i++)
			out_vec[i] <= dv_side_sn[DV_N].neg[i] ? -lim[i] : lim[i];
	end

endmodule

[src/crg_rotate.sv]
// ----------------------------------------------------------------------------
// crg_rotate
// holds the look-at basis, derives the up vector and rotates camera rays
// into world space
// ----------------------------------------------------------------------------
module crg_rotate (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  crg_pkg::side_t                    in_side,
	input  logic [2:0][crg_pkg::VEC_W-1:0]    in_vec,
	input  logic                              degen,
	output logic                              done,
	output crg_pkg::ray_t                     result
);

	logic signed [crg_pkg::VEC_W-1:0]  f_q  [3];
	logic signed [crg_pkg::VEC_W-1:0]  s_q  [3];
	logic signed [crg_pkg::VEC_W-1:0]  u_q  [3];
	logic signed [crg_pkg::PROD_W-1:0] up_q [6];

	logic signed [crg_pkg::PROD_W-1:0] mp_s1 [3][3];
	logic                              valid_s1;
	logic                              oof_s1;
	logic signed [crg_pkg::PROD_W-1:0] acc [3];
	logic signed [crg_pkg::VEC_W-1:0]  rv  [3];

	// basis capture
	always_ff @(posedge clk) begin
		if (in_valid && in_side.kind == crg_pkg::KIND_FWD)
			for (int i = 0; i < 3; i++) f_q[i] <= $signed(in_vec[i]);
		if (in_valid && in_side.kind == crg_pkg::KIND_SIDE)
			for (int i = 0; i < 3; i++) s_q[i] <= $signed(in_vec[i]);
	end

	// up = side x forward
	always_ff @(posedge clk) begin
		up_q[0] <= s_q[1] * f_q[2];
		up_q[1] <= s_q[2] * f_q[1];
		up_q[2] <= s_q[2] * f_q[0];
		up_q[3] <= s_q[0] * f_q[2];
		up_q[4] <= s_q[0] * f_q[1];
		up_q[5] <= s_q[1] * f_q[0];
		u_q[0]  <= crg_pkg::rnd_clamp(up_q[0] - up_q[1]);
		u_q[1]  <= crg_pkg::rnd_clamp(up_q[2] - up_q[3]);
		u_q[2]  <= crg_pkg::rnd_clamp(up_q[4] - up_q[5]);
	end

	// world ray
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done     <= 1'b0;
		end else begin
			valid_s1 <= in_valid && in_side.kind == crg_pkg::KIND_PIX;
			done     <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		oof_s1 <= in_side.oof;
		for (int i = 0; i < 3; i++) begin
			mp_s1[i][0] <= s_q[i] * $signed(in_vec[0]);
			mp_s1[i][1] <= u_q[i] * $signed(in_vec[1]);
			mp_s1[i][2] <= f_q[i] * $signed(in_vec[2]);
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			acc[i] = mp_s1[i][0] + mp_s1[i][1] - mp_s1[i][2];
			rv[i]  = degen ? '0 : crg_pkg::rnd_clamp(acc[i]);
		end
	end

	always_ff @(posedge clk) begin
		result.ray_x        <= rv[0];
		result.ray_y        <= rv[1];
		result.ray_z        <= rv[2];
		result.degenerate   <= degen;
		result.out_of_frame <= oof_s1;
	end

endmodule

[src/perspective_camera_ray_generator.sv]
// ----------------------------------------------------------------------------
// perspective_camera_ray_generator
// pinhole camera primary ray generation: pixel in, unit world ray out
// throughput: one request per cycle while busy is low; the normalizer is fully pipelined
// reset and every register write start a basis rebuild (busy high) that runs the
// view basis through the same normalizer; results are never held
// ----------------------------------------------------------------------------
module perspective_camera_ray_generator (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  crg_pkg::pixel_t     pixel,
	output logic                done,
	output crg_pkg::ray_t       result,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [4:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	localparam int RAW_W = crg_pkg::RAW_W;
	localparam int WID_W = 31;

	crg_pkg::cfg_t cfg;
	logic          wr;
	logic [crg_pkg::CNT_W-1:0] cnt_q;

	crg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg),
		.wr      (wr)
	);

	// basis rebuild sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)          cnt_q <= crg_pkg::CNT_W'(crg_pkg::BASIS_CYCLES);
		else if (wr)          cnt_q <= crg_pkg::CNT_W'(crg_pkg::BASIS_CYCLES);
		else if (cnt_q != '0) cnt_q <= cnt_q - 1'b1;
	end

	assign busy = (cnt_q != '0);

	// entry
	logic [crg_pkg::DIM_W-1:0] w_eff, h_eff;
	logic signed [13:0]        ax, ay;
	logic                      acc_pix, inj_f, inj_s;
	logic signed [RAW_W-1:0]   v_n [3];
	crg_pkg::kind_t            kind_n;

	always_comb begin
		w_eff = (cfg.frame_width == '0) ? crg_pkg::DIM_W'(1)
		      : (cfg.frame_width > crg_pkg::DIM_W'(crg_pkg::MAX_DIM))
		      ? crg_pkg::DIM_W'(crg_pkg::MAX_DIM) : cfg.frame_width;
		h_eff = (cfg.frame_height == '0) ? crg_pkg::DIM_W'(1)
		      : (cfg.frame_height > crg_pkg::DIM_W'(crg_pkg::MAX_DIM))
		      ? crg_pkg::DIM_W'(crg_pkg::MAX_DIM) : cfg.frame_height;
		ax = $signed({1'b0, pixel.pixel_x, 1'b0}) - $signed({1'b0, w_eff});
		ay = $signed({1'b0, pixel.pixel_y, 1'b0}) - $signed({1'b0, h_eff});
		acc_pix = start && !busy;
		inj_f   = (cnt_q == crg_pkg::CNT_W'(crg_pkg::BASIS_CYCLES));
		inj_s   = (cnt_q == crg_pkg::CNT_W'(crg_pkg::BASIS_CYCLES - 1));
		if (inj_f) begin
			kind_n = crg_pkg::KIND_FWD;
			v_n[0] = {cfg.dir_x[15], cfg.dir_x};
			v_n[1] = {cfg.dir_y[15], cfg.dir_y};
			v_n[2] = {cfg.dir_z[15], cfg.dir_z};
		end else if (inj_s) begin
			kind_n = crg_pkg::KIND_SIDE;
			v_n[0] = -$signed({cfg.dir_z[15], cfg.dir_z});
			v_n[1] = '0;
			v_n[2] = {cfg.dir_x[15], cfg.dir_x};
		end else begin
			kind_n = crg_pkg::KIND_PIX;
			v_n[0] = {{(RAW_W-14){ax[13]}}, ax};
			v_n[1] = {{(RAW_W-14){ay[13]}}, ay};
			v_n[2] = -$signed({{(RAW_W-crg_pkg::DIM_W){1'b0}}, h_eff});
		end
	end

	logic                    valid_s1, valid_s2, valid_s3;
	crg_pkg::kind_t          kind_s1, kind_s2;
	logic                    oof_s1, oof_s2;
	logic signed [RAW_W-1:0] v_s1 [3];
	logic signed [WID_W-1:0] w_s2 [3];
	crg_pkg::side_t          side_s3;
	logic [2:0][crg_pkg::MAG_W-1:0] mag_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= acc_pix || inj_f || inj_s;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	logic signed [RAW_W-1:0]   fac [3];
	logic signed [2*RAW_W-1:0] prod [3];
	logic signed [WID_W-1:0]   absw [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (kind_s1 != crg_pkg::KIND_PIX) fac[i] = RAW_W'(1);
			else if (i == 2)                  fac[i] = RAW_W'(1 << crg_pkg::TAN_FRAC);
			else                              fac[i] = $signed({1'b0, cfg.tan_half_fov});
			prod[i] = v_s1[i] * fac[i];
			absw[i] = w_s2[i][WID_W-1] ? -w_s2[i] : w_s2[i];
		end
	end

	always_ff @(posedge clk) begin
		kind_s1 <= kind_n;
		oof_s1  <= ({1'b0, pixel.pixel_x} >= w_eff) || ({1'b0, pixel.pixel_y} >= h_eff);
		v_s1    <= v_n;
		kind_s2 <= kind_s1;
		oof_s2  <= oof_s1;
		for (int i = 0; i < 3; i++) begin
			w_s2[i]        <= prod[i][WID_W-1:0];
			side_s3.neg[i] <= w_s2[i][WID_W-1];
			mag_s3[i]      <= absw[i][crg_pkg::MAG_W-1:0];
		end
		side_s3.kind <= kind_s2;
		side_s3.oof  <= oof_s2;
	end

	logic                           nv;
	crg_pkg::side_t                 nside;
	logic [2:0][crg_pkg::VEC_W-1:0] nvec;

	crg_norm u_norm (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s3),
		.in_side   (side_s3),
		.in_mag    (mag_s3),
		.out_valid (nv),
		.out_side  (nside),
		.out_vec   (nvec)
	);

	crg_rotate u_rotate (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (nv),
		.in_side  (nside),
		.in_vec   (nvec),
		.degen    ((cfg.dir_x == '0) && (cfg.dir_z == '0)),
		.done     (done),
		.result   (result)
	);

endmodule
